// ===== src/segcirc_pkg.sv =====
// Shared constants and stage types for the thick segment versus circle test.
// Used by segment_circle_collision; depends on nothing else.
`default_nettype none

package segcirc_pkg;

  // Fraction bits of the projection parameter t.
  localparam int unsigned T_BITS     = 30;
  // Result bits of a 64 bit integer square root.
  localparam int unsigned SQ_STEPS   = 32;
  // Quotient bits of a normal component (up to 1.0 in Q1.14).
  localparam int unsigned NQ_BITS    = 15;
  localparam int unsigned NORM_SHIFT = 14;
  localparam logic [NQ_BITS-1:0] NORM_ONE = NQ_BITS'(16384);
  localparam logic [T_BITS:0]    T_ONE    = (T_BITS+1)'(1) << T_BITS;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_OFS_X  = 2'd1,
    CFG_OFS_Y  = 2'd2
  } cfg_idx_t;

  // Segment geometry carried through the projection and divider stages.
  typedef struct packed {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic signed [31:0] dirx;
    logic signed [31:0] diry;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic [31:0]        rsum;
    logic [31:0]        mdx;
    logic [31:0]        mdy;
  } geo_t;

  // Result data carried through the square root and normal stages.
  typedef struct packed {
    logic        hit;
    logic [31:0] hx;
    logic [31:0] hy;
    logic [31:0] rsum;
    logic        negx;
    logic        negy;
    logic        zero;
    logic [63:0] dist2;
    logic [31:0] nax;
    logic [31:0] nay;
  } post_t;

endpackage

`default_nettype wire

// ===== src/segment_circle_collision.sv =====
// Thick segment versus circle collision test, fully pipelined.
// Depends on segcirc_pkg for constants and stage types.
`default_nettype none

// A start beat is taken in every clock cycle (busy stays low) and its result
// is shown on out_valid and the out_ ports for one cycle; the receiver cannot
// stall. The pipeline holds the 30 stage divider for t, the 32 stage square
// roots for the distance and the normal length, and the 15 stage dividers for
// the normal components. Configuration writes take effect at once and must be
// made while no beat is in flight.
module segment_circle_collision (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_seg_start_x,
  input  logic signed [31:0] in_seg_start_y,
  input  logic signed [31:0] in_seg_end_x,
  input  logic signed [31:0] in_seg_end_y,
  input  logic [30:0]        in_seg_thickness,
  input  logic signed [31:0] in_entity_x,
  input  logic signed [31:0] in_entity_y,
  output logic               out_valid,
  output logic               out_collided,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic [30:0]        out_penetration_depth,
  output logic signed [15:0] out_normal_x,
  output logic signed [15:0] out_normal_y
);
  import segcirc_pkg::*;

  logic [30:0]        radius_r;
  logic signed [31:0] ofs_x_r, ofs_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= '0;
      ofs_x_r  <= '0;
      ofs_y_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS: radius_r <= cfg_wdata[30:0];
        CFG_OFS_X:  ofs_x_r  <= cfg_wdata;
        CFG_OFS_Y:  ofs_y_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- front end: centre, direction, dot product ----------------
  logic v1_r, v2_r, v3_r, v4_r;
  geo_t g1_r, g1m, g2_r, g3_r, g4_r;
  logic signed [31:0] difx2_r, dify2_r;
  logic signed [63:0] p1_r, p2_r;
  logic [63:0] qx_r, qy_r;
  logic signed [64:0] dsum;
  logic [63:0] dot4_r, len4_r;
  logic pos4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= start;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    g1m     = g1_r;
    g1m.mdx = g1_r.dirx[31] ? 32'(-g1_r.dirx) : g1_r.dirx;
    g1m.mdy = g1_r.diry[31] ? 32'(-g1_r.diry) : g1_r.diry;
  end

  assign dsum = $signed({p1_r[63], p1_r}) + $signed({p2_r[63], p2_r});

  always_ff @(posedge clk) begin
    g1_r.sx   <= in_seg_start_x;
    g1_r.sy   <= in_seg_start_y;
    g1_r.dirx <= in_seg_end_x - in_seg_start_x;
    g1_r.diry <= in_seg_end_y - in_seg_start_y;
    g1_r.cx   <= in_entity_x + ofs_x_r;
    g1_r.cy   <= in_entity_y + ofs_y_r;
    g1_r.rsum <= {1'b0, radius_r} + {1'b0, in_seg_thickness};
    g1_r.mdx  <= '0;
    g1_r.mdy  <= '0;

    g2_r    <= g1m;
    difx2_r <= g1_r.cx - g1_r.sx;
    dify2_r <= g1_r.cy - g1_r.sy;

    g3_r <= g2_r;
    p1_r <= $signed(difx2_r) * $signed(g2_r.dirx);
    p2_r <= $signed(dify2_r) * $signed(g2_r.diry);
    qx_r <= $signed(g2_r.dirx) * $signed(g2_r.dirx);
    qy_r <= $signed(g2_r.diry) * $signed(g2_r.diry);

    g4_r   <= g3_r;
    dot4_r <= dsum[63:0];
    len4_r <= qx_r + qy_r;
    pos4_r <= !dsum[64] && (dsum != '0);
  end

  // ---------------- restoring divider for t, one bit a stage ----------------
  logic [T_BITS:0]  dv_r;
  logic [63:0]      drem_r [0:T_BITS];
  logic [63:0]      dlen_r [0:T_BITS];
  logic [T_BITS-1:0] dq_r  [0:T_BITS];
  logic [T_BITS:0]  dtz_r, dto_r;
  geo_t             dg_r   [0:T_BITS];
  logic             tz, to;

  assign tz = (len4_r == '0) || !pos4_r;
  assign to = dot4_r >= len4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else begin
      dv_r <= {dv_r[T_BITS-1:0], v4_r};
    end
  end

  always_ff @(posedge clk) begin
    logic [64:0] sh;
    logic        ge;
    drem_r[0] <= (tz || to) ? '0 : dot4_r;
    dlen_r[0] <= len4_r;
    dq_r[0]   <= '0;
    dtz_r[0]  <= tz;
    dto_r[0]  <= to;
    dg_r[0]   <= g4_r;
    for (int k = 0; k < T_BITS; k++) begin
      sh = {drem_r[k], 1'b0};
      ge = sh >= {1'b0, dlen_r[k]};
      drem_r[k+1] <= ge ? 64'(sh - {1'b0, dlen_r[k]}) : sh[63:0];
      dlen_r[k+1] <= dlen_r[k];
      dq_r[k+1]   <= {dq_r[k][T_BITS-2:0], ge};
      dtz_r[k+1]  <= dtz_r[k];
      dto_r[k+1]  <= dto_r[k];
      dg_r[k+1]   <= dg_r[k];
    end
  end

  // ---------------- closest point and squared distance ----------------
  logic vm_r, vo_r, vh_r, vd_r, vq_r, vc_r, vl_r, vn_r, vs_r;
  logic [T_BITS:0]  tval;
  logic [62:0]      mpx_r, mpy_r;
  geo_t             gm_r, go_r, gh_r;
  logic [63:0]      ox_sum, oy_sum;
  logic [31:0]      offx_r, offy_r;
  logic signed [31:0] hx_r, hy_r;
  logic signed [31:0] dx_r, dy_r;
  logic [31:0]      hxd_r, hyd_r, rsd_r;
  logic [63:0]      dxs_r, dys_r, rsq_r, dist2;
  logic [31:0]      axq_r, ayq_r, mxc_r;
  post_t            pq_r, pc_r, pl_r, pn_r, ps_r;
  post_t            pc_nxt, pn_nxt;
  logic [4:0]       msb, shamt, shl_r;
  logic [63:0]      sqx_r, sqy_r;

  assign tval   = dtz_r[T_BITS] ? '0 :
                  dto_r[T_BITS] ? T_ONE : {1'b0, dq_r[T_BITS]};
  assign ox_sum = {1'b0, mpx_r} + (64'd1 << (T_BITS - 1));
  assign oy_sum = {1'b0, mpy_r} + (64'd1 << (T_BITS - 1));
  assign dist2  = dxs_r + dys_r;

  always_comb begin
    msb = '0;
    for (int i = 0; i < 32; i++) begin
      if (mxc_r[i]) msb = 5'(i);
    end
    // Only vectors whose larger component is below 2^30 are scaled up.
    if (mxc_r == '0 || mxc_r[31:30] != 2'b00) shamt = '0;
    else shamt = 5'd30 - msb;
  end

  always_comb begin
    pc_nxt       = pq_r;
    pc_nxt.hit   = dist2 <= rsq_r;
    pc_nxt.zero  = dist2 == '0;
    pc_nxt.dist2 = dist2;
    pc_nxt.nax   = axq_r;
    pc_nxt.nay   = ayq_r;
    pn_nxt       = pl_r;
    pn_nxt.nax   = pl_r.nax << shl_r;
    pn_nxt.nay   = pl_r.nay << shl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
      vo_r <= 1'b0;
      vh_r <= 1'b0;
      vd_r <= 1'b0;
      vq_r <= 1'b0;
      vc_r <= 1'b0;
      vl_r <= 1'b0;
      vn_r <= 1'b0;
      vs_r <= 1'b0;
    end else begin
      vm_r <= dv_r[T_BITS];
      vo_r <= vm_r;
      vh_r <= vo_r;
      vd_r <= vh_r;
      vq_r <= vd_r;
      vc_r <= vq_r;
      vl_r <= vc_r;
      vn_r <= vl_r;
      vs_r <= vn_r;
    end
  end

  always_ff @(posedge clk) begin
    gm_r  <= dg_r[T_BITS];
    mpx_r <= tval * dg_r[T_BITS].mdx;
    mpy_r <= tval * dg_r[T_BITS].mdy;

    go_r   <= gm_r;
    offx_r <= ox_sum[T_BITS+31:T_BITS];
    offy_r <= oy_sum[T_BITS+31:T_BITS];

    gh_r <= go_r;
    hx_r <= go_r.dirx[31] ? go_r.sx - offx_r : go_r.sx + offx_r;
    hy_r <= go_r.diry[31] ? go_r.sy - offy_r : go_r.sy + offy_r;

    dx_r  <= gh_r.cx - hx_r;
    dy_r  <= gh_r.cy - hy_r;
    hxd_r <= hx_r;
    hyd_r <= hy_r;
    rsd_r <= gh_r.rsum;

    dxs_r <= $signed(dx_r) * $signed(dx_r);
    dys_r <= $signed(dy_r) * $signed(dy_r);
    rsq_r <= rsd_r * rsd_r;
    axq_r <= dx_r[31] ? 32'(-dx_r) : dx_r;
    ayq_r <= dy_r[31] ? 32'(-dy_r) : dy_r;
    pq_r  <= '{hit: 1'b0, hx: hxd_r, hy: hyd_r, rsum: rsd_r, negx: dx_r[31],
               negy: dy_r[31], zero: 1'b0, dist2: '0, nax: '0, nay: '0};

    pc_r  <= pc_nxt;
    mxc_r <= (axq_r > ayq_r) ? axq_r : ayq_r;

    pl_r  <= pc_r;
    shl_r <= shamt;

    pn_r <= pn_nxt;

    ps_r  <= pn_r;
    sqx_r <= pn_r.nax * pn_r.nax;
    sqy_r <= pn_r.nay * pn_r.nay;
  end

  // ---------------- two square roots side by side, one bit a stage ----------------
  // Lane 0 gives the distance, lane 1 the length of the scaled difference vector.
  logic [SQ_STEPS:0] sqv_r;
  logic [63:0] sv0_r [0:SQ_STEPS];
  logic [63:0] sr0_r [0:SQ_STEPS];
  logic [63:0] sv1_r [0:SQ_STEPS];
  logic [63:0] sr1_r [0:SQ_STEPS];
  post_t       sp_r  [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sqv_r <= '0;
    end else begin
      sqv_r <= {sqv_r[SQ_STEPS-1:0], vs_r};
    end
  end

  always_ff @(posedge clk) begin
    logic [63:0] bitv;
    logic [64:0] tr0, tr1;
    logic        ok0, ok1;
    sv0_r[0] <= ps_r.dist2;
    sv1_r[0] <= sqx_r + sqy_r;
    sr0_r[0] <= '0;
    sr1_r[0] <= '0;
    sp_r[0]  <= ps_r;
    for (int k = 0; k < SQ_STEPS; k++) begin
      bitv = 64'd1 << (62 - 2 * k);
      tr0  = {1'b0, sr0_r[k]} + {1'b0, bitv};
      tr1  = {1'b0, sr1_r[k]} + {1'b0, bitv};
      ok0  = {1'b0, sv0_r[k]} >= tr0;
      ok1  = {1'b0, sv1_r[k]} >= tr1;
      sv0_r[k+1] <= ok0 ? 64'(sv0_r[k] - tr0[63:0]) : sv0_r[k];
      sv1_r[k+1] <= ok1 ? 64'(sv1_r[k] - tr1[63:0]) : sv1_r[k];
      sr0_r[k+1] <= ok0 ? (sr0_r[k] >> 1) + bitv : sr0_r[k] >> 1;
      sr1_r[k+1] <= ok1 ? (sr1_r[k] >> 1) + bitv : sr1_r[k] >> 1;
      sp_r[k+1]  <= sp_r[k];
    end
  end

  // ---------------- penetration and normal dividers ----------------
  logic [31:0] dist_val, slen;
  logic [32:0] pd_a, pd_b;
  logic [31:0] pabs;
  logic [30:0] pen;

  assign dist_val = sr0_r[SQ_STEPS][31:0];
  assign slen     = sr1_r[SQ_STEPS][31:0];
  assign pd_a = {1'b0, dist_val} - {1'b0, sp_r[SQ_STEPS].rsum};
  assign pd_b = {1'b0, sp_r[SQ_STEPS].rsum} - {1'b0, dist_val};
  assign pabs = pd_a[32] ? pd_b[31:0] : pd_a[31:0];
  assign pen  = pabs[31] ? '1 : pabs[30:0];

  logic [NQ_BITS:0]  nv_r;
  logic [46:0]       nrx_r  [0:NQ_BITS];
  logic [46:0]       nry_r  [0:NQ_BITS];
  logic [NQ_BITS-1:0] nqx_r [0:NQ_BITS];
  logic [NQ_BITS-1:0] nqy_r [0:NQ_BITS];
  logic [31:0]       nlen_r [0:NQ_BITS];
  logic [30:0]       npen_r [0:NQ_BITS];
  post_t             np_r   [0:NQ_BITS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nv_r <= '0;
    end else begin
      nv_r <= {nv_r[NQ_BITS-1:0], sqv_r[SQ_STEPS]};
    end
  end

  always_ff @(posedge clk) begin
    logic [46:0] dd;
    logic        gx, gy;
    nrx_r[0]  <= {1'b0, sp_r[SQ_STEPS].nax, NORM_SHIFT'(0)} + {16'd0, slen[31:1]};
    nry_r[0]  <= {1'b0, sp_r[SQ_STEPS].nay, NORM_SHIFT'(0)} + {16'd0, slen[31:1]};
    nqx_r[0]  <= '0;
    nqy_r[0]  <= '0;
    nlen_r[0] <= slen;
    npen_r[0] <= pen;
    np_r[0]   <= sp_r[SQ_STEPS];
    for (int k = 0; k < NQ_BITS; k++) begin
      dd = {15'd0, nlen_r[k]} << (NQ_BITS - 1 - k);
      gx = nrx_r[k] >= dd;
      gy = nry_r[k] >= dd;
      nrx_r[k+1]  <= gx ? nrx_r[k] - dd : nrx_r[k];
      nry_r[k+1]  <= gy ? nry_r[k] - dd : nry_r[k];
      nqx_r[k+1]  <= {nqx_r[k][NQ_BITS-2:0], gx};
      nqy_r[k+1]  <= {nqy_r[k][NQ_BITS-2:0], gy};
      nlen_r[k+1] <= nlen_r[k];
      npen_r[k+1] <= npen_r[k];
      np_r[k+1]   <= np_r[k];
    end
  end

  // ---------------- output register ----------------
  post_t             pf;
  logic [NQ_BITS-1:0] nx_lim, ny_lim;
  logic signed [15:0] nx_s, ny_s;
  logic              show_n;

  assign pf     = np_r[NQ_BITS];
  assign nx_lim = (nqx_r[NQ_BITS] > NORM_ONE) ? NORM_ONE : nqx_r[NQ_BITS];
  assign ny_lim = (nqy_r[NQ_BITS] > NORM_ONE) ? NORM_ONE : nqy_r[NQ_BITS];
  assign nx_s   = pf.negx ? 16'(-{1'b0, nx_lim}) : {1'b0, nx_lim};
  assign ny_s   = pf.negy ? 16'(-{1'b0, ny_lim}) : {1'b0, ny_lim};
  assign show_n = pf.hit && !pf.zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= nv_r[NQ_BITS];
    end
  end

  always_ff @(posedge clk) begin
    out_collided          <= pf.hit;
    out_hit_x             <= pf.hit ? pf.hx : '0;
    out_hit_y             <= pf.hit ? pf.hy : '0;
    out_penetration_depth <= pf.hit ? npen_r[NQ_BITS] : '0;
    out_normal_x          <= show_n ? nx_s : '0;
    out_normal_y          <= show_n ? ny_s : '0;
  end

`ifndef SYNTHESIS
  // A miss carries no point, depth or normal.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_collided |-> out_hit_x == 0 && out_hit_y == 0 &&
      out_penetration_depth == 0 && out_normal_x == 0 && out_normal_y == 0)
    else $error("miss beat with non-zero result fields");

  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_x <= 16384 && out_normal_x >= -16384 &&
      out_normal_y <= 16384 && out_normal_y >= -16384)
    else $error("normal component out of range");

  // The t divider must leave a remainder below the squared length.
  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[T_BITS] && !dtz_r[T_BITS] |-> drem_r[T_BITS] < dlen_r[T_BITS])
    else $error("t divider remainder not below divisor");

  // A scaled non-zero difference vector has length of at least 2^30.
  a_len_scaled: assert property (@(posedge clk) disable iff (!rst_n)
    sqv_r[SQ_STEPS] && !sp_r[SQ_STEPS].zero |-> sr1_r[SQ_STEPS] >= 64'd1073741824)
    else $error("normal length below scaled range");
`endif

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for segment_circle_collision: directed and random segment beats.
// Depends on segcirc_pkg and segment_circle_collision; carries its own bit-exact predictor.
`default_nettype none

module tb;
  import segcirc_pkg::*;

  localparam int unsigned LATENCY   = 94;
  localparam int unsigned MAX_CYCLE = 400000;
  localparam logic [1:0]  CFG_SPARE = 2'd3;   // index with no register behind it
  localparam longint      Q_ONE     = 65536;

  typedef struct {
    logic               collided;
    logic signed [31:0] hx;
    logic signed [31:0] hy;
    logic [30:0]        pen;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
  } hit_rec_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_seg_start_x = '0, in_seg_start_y = '0;
  logic signed [31:0] in_seg_end_x = '0, in_seg_end_y = '0;
  logic [30:0] in_seg_thickness = '0;
  logic signed [31:0] in_entity_x = '0, in_entity_y = '0;
  logic out_valid, out_collided;
  logic signed [31:0] out_hit_x, out_hit_y;
  logic [30:0] out_penetration_depth;
  logic signed [15:0] out_normal_x, out_normal_y;

  // Configuration as the block should hold it.
  logic [30:0] radius_q = '0;
  logic signed [31:0] ofs_x_q = '0, ofs_y_q = '0;

  hit_rec_t hits_pending[$];
  int unsigned errors = 0, beats_sent = 0, results_seen = 0, hits_seen = 0;
  int unsigned cycle = 0;
  bit no_idle = 1'b0;

  segment_circle_collision dut (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle, hits_pending.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint w32(longint x);
    logic signed [31:0] s;
    s = x[31:0];
    return s;
  endfunction

  function automatic logic [63:0] absval(longint x);
    return (x < 0) ? -x : x;
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] res, bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] unit_comp(logic [63:0] c, logic [63:0] len, longint sgn);
    logic [63:0] n;
    n = (c * 16384 + len / 2) / len;
    if (n > 16384) n = 16384;
    if (sgn < 0) n = -n;
    return n[15:0];
  endfunction

  function automatic hit_rec_t capsule_hit(longint sx, longint sy, longint ex, longint ey,
                                           longint thick, longint entx, longint enty);
    hit_rec_t r;
    longint cx, cy, dirx, diry, difx, dify, p1, p2, offx, offy, hx, hy, dx, dy;
    logic [63:0] len2, dot, t, rem, dist2, rsum, dist_v, pen, ax, ay, m, len;
    cx = w32(entx + longint'(ofs_x_q));
    cy = w32(enty + longint'(ofs_y_q));
    dirx = w32(ex - sx);
    diry = w32(ey - sy);
    difx = w32(cx - sx);
    dify = w32(cy - sy);
    p1 = difx * dirx;
    p2 = dify * diry;
    len2 = (dirx * dirx) + (diry * diry);
    t = '0;
    if (len2 != 0 && p1 > -p2) begin
      dot = p1 + p2;
      if (dot >= len2) begin
        t = 64'd1 << 30;
      end else begin
        rem = dot;
        // Restoring division; the remainder stays below len2, so doubling it cannot overflow.
        for (int i = 0; i < 30; i++) begin
          rem = rem << 1;
          t = t << 1;
          if (rem >= len2) begin
            rem = rem - len2;
            t[0] = 1'b1;
          end
        end
      end
    end
    offx = (t * absval(dirx) + (64'd1 << 29)) >> 30;
    offy = (t * absval(diry) + (64'd1 << 29)) >> 30;
    if (dirx < 0) offx = -offx;
    if (diry < 0) offy = -offy;
    hx = w32(sx + offx);
    hy = w32(sy + offy);
    dx = w32(cx - hx);
    dy = w32(cy - hy);
    dist2 = (dx * dx) + (dy * dy);
    rsum = 64'(radius_q) + 64'(thick);
    r = '{default: '0};
    r.collided = (dist2 <= rsum * rsum);
    if (!r.collided) return r;
    r.hx = hx[31:0];
    r.hy = hy[31:0];
    dist_v = int_sqrt(dist2);
    pen = (dist_v > rsum) ? dist_v - rsum : rsum - dist_v;
    r.pen = (pen > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : pen[30:0];
    if (dist2 != 0) begin
      ax = absval(dx);
      ay = absval(dy);
      m = (ax > ay) ? ax : ay;
      while (m < (64'd1 << 30)) begin
        ax = ax << 1;
        ay = ay << 1;
        m = m << 1;
      end
      len = int_sqrt(ax * ax + ay * ay);
      r.nx = unit_comp(ax, len, dx);
      r.ny = unit_comp(ay, len, dy);
    end
    return r;
  endfunction

  // Result checker: the block cannot be stalled, so every strobe is a beat.
  always @(posedge clk) begin
    hit_rec_t e;
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (hits_pending.size() == 0) begin
        $display("%0t: result with nothing expected (collided %0b)", $time, out_collided);
        errors <= errors + 1;
      end else begin
        e = hits_pending.pop_front();
        if (out_collided) hits_seen <= hits_seen + 1;
        if (out_collided !== e.collided || out_hit_x !== e.hx || out_hit_y !== e.hy ||
            out_penetration_depth !== e.pen || out_normal_x !== e.nx ||
            out_normal_y !== e.ny) begin
          $display("%0t: mismatch expected col=%0b hit=(%0d,%0d) pen=%0d n=(%0d,%0d)",
                   $time, e.collided, e.hx, e.hy, e.pen, e.nx, e.ny);
          $display("%0t:          actual   col=%0b hit=(%0d,%0d) pen=%0d n=(%0d,%0d)",
                   $time, out_collided, out_hit_x, out_hit_y, out_penetration_depth,
                   out_normal_x, out_normal_y);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic idle_gap();
    int unsigned r, n;
    r = $urandom_range(0, 99);
    n = no_idle ? 0 : (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Drives one segment beat and waits until the block takes it.
  task automatic send_segment(longint sx, longint sy, longint ex, longint ey,
                              longint thick, longint entx, longint enty);
    in_seg_start_x <= sx[31:0];
    in_seg_start_y <= sy[31:0];
    in_seg_end_x <= ex[31:0];
    in_seg_end_y <= ey[31:0];
    in_seg_thickness <= thick[30:0];
    in_entity_x <= entx[31:0];
    in_entity_y <= enty[31:0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    hits_pending.push_back(capsule_hit(w32(sx), w32(sy), w32(ex), w32(ey),
                                       thick & 64'h7FFF_FFFF, w32(entx), w32(enty)));
    beats_sent++;
    idle_gap();
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (hits_pending.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RADIUS: radius_q = val[30:0];
      CFG_OFS_X:  ofs_x_q = val;
      CFG_OFS_Y:  ofs_y_q = val;
      default: ;
    endcase
  endtask

  task automatic set_circle(logic [30:0] rad, logic [31:0] ox, logic [31:0] oy);
    write_reg(CFG_RADIUS, {1'b0, rad});
    write_reg(CFG_OFS_X, ox);
    write_reg(CFG_OFS_Y, oy);
  endtask

  function automatic longint jitter(longint spread);
    return longint'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Mostly scenes built around the circle centre so that hits are common.
  task automatic random_segment();
    longint entx, enty, cx, cy, spread, thick;
    int unsigned mode;
    mode = $urandom_range(0, 9);
    if (mode < 2) begin
      send_segment(longint'($signed($urandom)), longint'($signed($urandom)),
                   longint'($signed($urandom)), longint'($signed($urandom)),
                   $urandom & 32'h7FFF_FFFF, longint'($signed($urandom)),
                   longint'($signed($urandom)));
    end else begin
      spread = longint'(1) << (2 * $urandom_range(2, 12));
      entx = longint'($signed($urandom));
      enty = longint'($signed($urandom));
      cx = w32(entx + longint'(ofs_x_q));
      cy = w32(enty + longint'(ofs_y_q));
      thick = (mode == 2) ? 0 : $urandom_range(0, int'(spread));
      if (mode == 3)
        send_segment(cx + jitter(spread), cy + jitter(spread), cx + jitter(spread),
                     cy + jitter(spread), thick, entx, enty);
      else if (mode == 4) begin
        // Degenerate segment: both ends the same point.
        cx = cx + jitter(spread);
        cy = cy + jitter(spread);
        send_segment(cx, cy, cx, cy, thick, entx, enty);
      end else
        send_segment(cx - spread + jitter(spread / 2), cy + jitter(spread),
                     cx + spread + jitter(spread / 2), cy + jitter(spread), thick, entx, enty);
    end
  endtask

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sh7FFF_FFFF;
    mn = -64'sh8000_0000;
    set_circle(31'(2 * Q_ONE), 32'(Q_ONE), -32'sd65536);
    send_segment(-10 * Q_ONE, -Q_ONE, 10 * Q_ONE, -Q_ONE, 0, 0, 0);   // centre on segment
    send_segment(-10 * Q_ONE, 0, 10 * Q_ONE, 0, Q_ONE / 2, 0, 0);     // crossing hit
    send_segment(5 * Q_ONE, 0, 5 * Q_ONE, 0, 0, 0, 0);                // zero length
    send_segment(3 * Q_ONE, 0, 9 * Q_ONE, 0, Q_ONE, 0, 0);            // t clamped to 0
    send_segment(-9 * Q_ONE, 0, -Q_ONE, -Q_ONE, Q_ONE, 0, 0);         // t clamped to 1
    send_segment(0, 20 * Q_ONE, Q_ONE, 20 * Q_ONE, 0, 0, 0);          // clear miss
    send_segment(0, 0, 0, 0, 0, Q_ONE, Q_ONE);                        // touching exactly
    send_segment(mx, mx, mn, mn, 31'h7FFF_FFFF, mx, mn);
    send_segment(mn, mn, mx, mx, 31'h7FFF_FFFF, mn, mx);
    send_segment(mx, 0, mn, 0, 0, mn, mx);                            // wrapping differences
    send_segment(mn, mn, mn, mn, 31'h7FFF_FFFF, mx, mx);
    send_segment(mx, mx, mx, mx, 1, mx, mx);
    send_segment(-1, -1, 1, 1, 31'h7FFF_FFFF, -1, 1);
    set_circle(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    send_segment(0, 0, 0, 0, 31'h7FFF_FFFF, 0, 0);
    send_segment(mn, mx, mx, mn, 31'h7FFF_FFFF, mx, mx);
    send_segment(0, 0, 100, 3, 0, 1, -1);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);                              // must change nothing
    send_segment(0, 0, 100, 3, 5, 1, -1);
    set_circle('0, '0, '0);
    send_segment(0, 0, 0, 0, 0, 0, 0);                                // all zero: hit, no normal
    send_segment(7, 7, 7, 7, 0, 7, 7);
  endtask

  task automatic test_random(int unsigned n);
    repeat (n) random_segment();
  endtask

  task automatic test_back_to_back(int unsigned n);
    no_idle = 1'b1;
    test_random(n);
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause();
    test_random(50);
    drain();                    // hold off until every outstanding beat has returned
    test_random(50);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    set_circle(31'(Q_ONE * 4), '0, '0);
    test_random(300);
    test_back_to_back(150);
    set_circle('0, 32'h7FFF_FFFF, 32'h8000_0000);
    test_random(250);
    set_circle(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    test_random(150);
    set_circle(31'($urandom_range(0, 1 << 20)), $urandom, $urandom);
    test_drain_pause();
    set_circle(31'($urandom), $urandom, $urandom);
    test_back_to_back(100);
    test_random(330);
    drain();
    repeat (LATENCY + 10) @(posedge clk);
    $display("Sent %0d segment beats: directed corner cases, then five random circle settings.",
             beats_sent);
    $display("%0d results checked, %0d of them hits.", results_seen, hits_seen);
    if (errors == 0 && hits_pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
